// ----- design/dqfa_pkg.sv -----
// ----------------------------------------------------------------------------
// dqfa_pkg
// shared types, constants and byte functions of the fixed-answer dns responder
// ----------------------------------------------------------------------------
package dqfa_pkg;

    localparam int HDR_LEN     = 12;
    localparam int ANS_LEN     = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam int POS_W  = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [7:0] FLAG_BIT_MASK = 8'h80;
    localparam logic [7:0] ANCOUNT_HI    = 8'h00;
    localparam logic [7:0] ANCOUNT_LO    = 8'h01;
    localparam logic [7:0] NAME_PTR_HI   = 8'hC0;
    localparam logic [7:0] NAME_PTR_LO   = 8'h0C;
    localparam logic [7:0] TTL_SECONDS   = 8'h3C;
    localparam logic [7:0] RDLENGTH_A    = 8'h04;

    localparam logic [POS_W-1:0] HDR_LAST_POS = POS_W'(HDR_LEN - 1);
    localparam logic [POS_W-1:0] ANS_LAST_IDX = POS_W'(ANS_LEN - 1);

    localparam logic [POS_W-1:0] HDR_FLAGS_HI = POS_W'(2);
    localparam logic [POS_W-1:0] HDR_FLAGS_LO = POS_W'(3);
    localparam logic [POS_W-1:0] HDR_ANC_HI   = POS_W'(6);
    localparam logic [POS_W-1:0] HDR_ANC_LO   = POS_W'(7);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       in_last;
    } query_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } reply_t;

    typedef enum logic [1:0] {
        CMD_STORE,
        CMD_HEADER,
        CMD_PASS
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
        logic             last;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HEADER,
        BK_ANSWER
    } back_state_t;

    // response header byte from the held query header byte
    function automatic logic [7:0] header_edit(input logic [POS_W-1:0] idx,
                                               input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (idx == HDR_FLAGS_HI || idx == HDR_FLAGS_LO)
            r = b | FLAG_BIT_MASK;
        else if (idx == HDR_ANC_HI)
            r = ANCOUNT_HI;
        else if (idx == HDR_ANC_LO)
            r = ANCOUNT_LO;
        return r;
    endfunction

    // byte of the appended a record
    function automatic logic [7:0] answer_byte(input logic [POS_W-1:0] idx,
                                               input logic [31:0] ipv4);
        logic [7:0] r;
        unique case (idx)
            4'd0:    r = NAME_PTR_HI;
            4'd1:    r = NAME_PTR_LO;
            4'd3:    r = 8'h01;
            4'd5:    r = 8'h01;
            4'd9:    r = TTL_SECONDS;
            4'd11:   r = RDLENGTH_A;
            4'd12:   r = ipv4[31:24];
            4'd13:   r = ipv4[23:16];
            4'd14:   r = ipv4[15:8];
            4'd15:   r = ipv4[7:0];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- design/dns_query_to_fixed_answer.sv -----
// ----------------------------------------------------------------------------
// dns_query_to_fixed_answer
// answers every dns query with one a record carrying a fixed ipv4 address
// ----------------------------------------------------------------------------
// query channel: one payload byte per transfer, in_last on the final byte.
// reply channel: one response byte per transfer, out_last on the final byte.
// a query shorter than 12 bytes produces no reply bytes at all.
// the 12 header bytes are held; after the twelfth byte the back end sends
// the header with qr and ra set and ancount forced to 1, then every later
// byte passes at one per cycle while the reply side keeps up, then a
// 16-byte answer follows the last byte. a passed byte goes through the
// queue and then the output register before it shows on the reply port;
// the header starts only once the back end has stored the twelfth byte.
// throughput: one query byte per cycle while the reply side keeps up; the
// header and answer bursts are set by the back end's single output port,
// and a stalled reply side fills the queue and then drops query_ready.
// cfg_we writes answer_ipv4 from cfg_wdata at once; it is read when the
// answer goes out. reset clears the position, queue and output valid, and
// answer_ipv4 to 0.
// ----------------------------------------------------------------------------
module dns_query_to_fixed_answer
    import dqfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        query_valid,
    output logic        query_ready,
    input  query_t      query,
    output logic        reply_valid,
    input  logic        reply_ready,
    output reply_t      reply,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    logic [31:0] answer_ipv4_reg;
    logic        q_full;
    logic        q_empty;
    logic        push;
    logic        pop;
    cmd_t        push_cmd;
    cmd_t        head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            answer_ipv4_reg <= '0;
        else if (cfg_we)
            answer_ipv4_reg <= cfg_wdata;
    end

    dqfa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_valid),
        .query_ready (query_ready),
        .query       (query),
        .q_full      (q_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    dqfa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    dqfa_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head        (head),
        .pop         (pop),
        .ipv4        (answer_ipv4_reg),
        .reply_valid (reply_valid),
        .reply_ready (reply_ready),
        .reply       (reply)
    );

endmodule

// ----- design/dqfa_front.sv -----
// ----------------------------------------------------------------------------
// dqfa_front
// accepts query bytes, tracks the header position and tags each byte
// ----------------------------------------------------------------------------
module dqfa_front
    import dqfa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   query_valid,
    output logic   query_ready,
    input  query_t query,
    input  logic   q_full,
    output logic   push,
    output cmd_t   cmd
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             accept;

    assign query_ready = !q_full;
    assign accept      = query_valid && query_ready;

    always_comb
    begin
        cmd.data = query.data_byte;
        cmd.last = query.in_last;
        cmd.pos  = pos_reg;
        push     = 1'b0;
        priority if (pos_reg == HDR_LAST_POS)
        begin
            cmd.kind = CMD_HEADER;
            push     = accept;
        end
        else if (pos_reg < HDR_LAST_POS)
        begin
            cmd.kind = CMD_STORE;
            // short query ends here: nothing goes out
            push     = accept && !query.in_last;
        end
        else
        begin
            cmd.kind = CMD_PASS;
            push     = accept;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (query.in_last)
                pos_next = '0;
            else if (pos_reg <= HDR_LAST_POS)
                pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

// ----- design/dqfa_queue.sv -----
// ----------------------------------------------------------------------------
// dqfa_queue
// short fifo of tagged bytes between the front and the back
// ----------------------------------------------------------------------------
module dqfa_queue
    import dqfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- design/dqfa_back.sv -----
// ----------------------------------------------------------------------------
// dqfa_back
// holds the header, emits the edited header, passed bytes and the answer
// ----------------------------------------------------------------------------
module dqfa_back
    import dqfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  cmd_t        head,
    output logic        pop,
    input  logic [31:0] ipv4,
    output logic        reply_valid,
    input  logic        reply_ready,
    output reply_t      reply
);

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [POS_W-1:0] idx_reg;
    logic [POS_W-1:0] idx_next;
    logic             pend_last_reg;
    logic             pend_last_next;
    logic [7:0]       hdr_reg [HDR_LEN];
    logic             hdr_we;
    logic             reply_valid_reg;
    reply_t           reply_reg;
    logic             load;
    logic             emit;
    reply_t           emit_item;

    // output slot free or being taken this cycle
    assign load        = !reply_valid_reg || reply_ready;
    assign reply_valid = reply_valid_reg;
    assign reply       = reply_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && head.kind == CMD_HEADER)
                    state_next = BK_HEADER;
                else if (!q_empty && head.kind == CMD_PASS && load && head.last)
                    state_next = BK_ANSWER;
            end
            BK_HEADER:
            begin
                if (load && idx_reg == HDR_LAST_POS)
                    state_next = pend_last_reg ? BK_ANSWER : BK_IDLE;
            end
            BK_ANSWER:
            begin
                if (load && idx_reg == ANS_LAST_IDX)
                    state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        hdr_we         = 1'b0;
        emit           = 1'b0;
        emit_item      = '0;
        idx_next       = idx_reg;
        pend_last_next = pend_last_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (head.kind)
                        CMD_STORE:
                        begin
                            pop    = 1'b1;
                            hdr_we = 1'b1;
                        end
                        CMD_HEADER:
                        begin
                            pop            = 1'b1;
                            hdr_we         = 1'b1;
                            pend_last_next = head.last;
                            idx_next       = '0;
                        end
                        CMD_PASS:
                        begin
                            if (load)
                            begin
                                pop                = 1'b1;
                                emit               = 1'b1;
                                emit_item.out_byte = head.data;
                                emit_item.out_last = 1'b0;
                            end
                        end
                        default: pop = 1'b1;
                    endcase
                end
            end
            BK_HEADER:
            begin
                if (load)
                begin
                    emit               = 1'b1;
                    emit_item.out_byte = header_edit(idx_reg, hdr_reg[idx_reg]);
                    emit_item.out_last = 1'b0;
                    idx_next = (idx_reg == HDR_LAST_POS) ? '0 : idx_reg + 1'b1;
                end
            end
            BK_ANSWER:
            begin
                if (load)
                begin
                    emit               = 1'b1;
                    emit_item.out_byte = answer_byte(idx_reg, ipv4);
                    emit_item.out_last = (idx_reg == ANS_LAST_IDX);
                    idx_next = (idx_reg == ANS_LAST_IDX) ? '0 : idx_reg + 1'b1;
                end
            end
            default: idx_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            idx_reg         <= '0;
            pend_last_reg   <= 1'b0;
            reply_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_last_reg <= pend_last_next;
            if (emit)
                reply_valid_reg <= 1'b1;
            else if (reply_ready)
                reply_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            reply_reg <= emit_item;
        if (hdr_we)
            hdr_reg[head.pos] <= head.data;
    end

endmodule

// ----- design/dqfa_checker.sv -----
// ----------------------------------------------------------------------------
// dqfa_checker
// port-level checks of the responder, bound to the top level
// ----------------------------------------------------------------------------
module dqfa_checker
    import dqfa_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   reply_valid,
    input logic   reply_ready,
    input reply_t reply
);

    // a held reply stays offered
    a_reply_hold: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && !reply_ready |=> reply_valid)
        else $error("reply valid dropped while stalled");

    // a held reply keeps its payload
    a_reply_stable: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && !reply_ready |=> $stable(reply))
        else $error("reply payload changed while stalled");

    // an answer is 16 bytes long, so two last bytes never follow each other
    a_last_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && reply_ready && reply.out_last
        |=> !(reply_valid && reply.out_last))
        else $error("back-to-back last reply bytes");

    // nothing can be offered right out of reset
    a_reset_quiet: assert property (@(posedge clk)
        !$past(rst_n) |-> !reply_valid)
        else $error("reply valid right after reset");

endmodule

bind dns_query_to_fixed_answer dqfa_checker u_dqfa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .reply_valid (reply_valid),
    .reply_ready (reply_ready),
    .reply       (reply)
);

// ----- sim/dns_query_to_fixed_answer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_to_fixed_answer_tb
// checks the fixed-answer dns responder byte for byte against a predictor
// ----------------------------------------------------------------------------
// query bytes are sent as directed queries first, then as random queries of
// mixed length (short dropped ones, exact headers, longer passthroughs).
// every accepted query byte updates a predictor that queues the expected
// reply bytes; every accepted reply byte is checked against the oldest one.
// phases vary sender idling, receiver stalls and the answer address, and one
// phase holds the reply side off long enough to back up the query side.
// ----------------------------------------------------------------------------
module dns_query_to_fixed_answer_tb;
    import dqfa_pkg::*;

    localparam int          STALL_LIMIT = 4000;
    localparam int          DRAIN_SLACK = 12;
    localparam int          HOLDOFF_LEN = 300;
    localparam int          PHASE_BYTES = 20;
    localparam int          HOLD_BYTES  = 40;
    localparam logic [31:0] IPV4_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] IPV4_ZERO   = 32'h0000_0000;

    // predictor of the reply stream, with its own header copy and address
    class dns_reply_model;
        localparam int QR_BYTE   = 2;
        localparam int RA_BYTE   = 3;
        localparam int ANC_HI    = 6;
        localparam int ANC_LO    = 7;
        localparam int HDR_BYTES = 12;
        localparam int ANS_BYTES = 16;

        logic [7:0]  header_bytes [HDR_BYTES];
        int unsigned header_count;
        logic [31:0] ipv4;
        reply_t      pending_replies [$];
        int unsigned mismatches;

        function new();
            header_count = 0;
            ipv4         = '0;
            mismatches   = 0;
        endfunction

        function void set_ipv4(input logic [31:0] v);
            ipv4 = v;
        endfunction

        function void push_reply(input logic [7:0] b, input logic l);
            reply_t r;
            r.out_byte = b;
            r.out_last = l;
            pending_replies.push_back(r);
        endfunction

        function int unsigned pending_count();
            return pending_replies.size();
        endfunction

        function void take_query(input query_t q);
            logic [7:0] h;
            logic [7:0] rec [ANS_BYTES];
            if (header_count < HDR_BYTES)
            begin
                header_bytes[header_count] = q.data_byte;
                header_count++;
                if (header_count < HDR_BYTES)
                begin
                    // short query: dropped without any reply
                    if (q.in_last)
                        header_count = 0;
                    return;
                end
                for (int i = 0; i < HDR_BYTES; i++)
                begin
                    h = header_bytes[i];
                    if (i == QR_BYTE || i == RA_BYTE)
                        h = h | 8'h80;
                    else if (i == ANC_HI)
                        h = 8'h00;
                    else if (i == ANC_LO)
                        h = 8'h01;
                    push_reply(h, 1'b0);
                end
            end
            else
            begin
                push_reply(q.data_byte, 1'b0);
            end
            if (q.in_last)
            begin
                rec = '{8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00,
                        8'h00, 8'h3C, 8'h00, 8'h04,
                        ipv4[31:24], ipv4[23:16], ipv4[15:8], ipv4[7:0]};
                for (int i = 0; i < ANS_BYTES; i++)
                    push_reply(rec[i], i == ANS_BYTES - 1);
                header_count = 0;
            end
        endfunction

        function void check_reply(input reply_t r);
            reply_t e;
            if (pending_replies.size() == 0)
            begin
                $error("unexpected reply transfer: out_byte %h out_last %b",
                       r.out_byte, r.out_last);
                mismatches++;
                return;
            end
            e = pending_replies.pop_front();
            if (r.out_byte !== e.out_byte)
            begin
                $error("out_byte: expected %h, actual %h", e.out_byte, r.out_byte);
                mismatches++;
            end
            if (r.out_last !== e.out_last)
            begin
                $error("out_last: expected %b, actual %b", e.out_last, r.out_last);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        query_valid;
    logic        query_ready;
    query_t      query;
    logic        reply_valid;
    logic        reply_ready;
    reply_t      reply;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    dns_reply_model reply_model;
    int unsigned    send_idle_pct;
    int unsigned    recv_stall_pct;
    int unsigned    holdoff_request;
    int unsigned    holdoff_left;
    int unsigned    quiet_cycles;

    dns_query_to_fixed_answer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_valid),
        .query_ready (query_ready),
        .query       (query),
        .reply_valid (reply_valid),
        .reply_ready (reply_ready),
        .reply       (reply),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    always #5 clk = ~clk;

    // one query byte, with optional idle cycles ahead of it
    task automatic send_query_byte(input logic [7:0] b, input logic l);
        query_t q;
        q.data_byte = b;
        q.in_last   = l;
        while ($urandom_range(99) < send_idle_pct)
        begin
            query_valid <= 1'b0;
            @(posedge clk);
        end
        query_valid <= 1'b1;
        query       <= q;
        @(posedge clk);
        while (!query_ready)
            @(posedge clk);
        reply_model.take_query(q);
    endtask

    task automatic send_query(input int unsigned len, input logic [7:0] fill);
        for (int unsigned i = 0; i < len; i++)
            send_query_byte(fill, i == len - 1);
    endtask

    // mostly well-formed queries with random content, some short ones
    task automatic send_random_queries(input int unsigned n_bytes);
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        sent = 0;
        while (sent < n_bytes)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                len = $urandom_range(11, 1);
            else if (pick < 30)
                len = 12;
            else
                len = $urandom_range(40, 13);
            for (int unsigned i = 0; i < len; i++)
                send_query_byte(8'($urandom_range(255)), i == len - 1);
            sent += len;
        end
        query_valid <= 1'b0;
        @(posedge clk);
    endtask

    // short queries give no reply, so leave slack after the last expected byte
    task automatic wait_replies_drained();
        query_valid <= 1'b0;
        while (reply_model.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_answer_ipv4(input logic [31:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        reply_model.set_ipv4(v);
    endtask

    // reply side: checks every transfer and paces reply_ready
    initial
    begin
        reply_ready  <= 1'b0;
        holdoff_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && reply_valid && reply_ready)
                reply_model.check_reply(reply);
            if (holdoff_request != 0)
            begin
                holdoff_left    = holdoff_request;
                holdoff_request = 0;
            end
            if (holdoff_left != 0)
            begin
                holdoff_left--;
                reply_ready <= 1'b0;
            end
            else
            begin
                reply_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ends the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (query_valid && query_ready) || (reply_valid && reply_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        reply_model     = new();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        holdoff_request = 0;
        rst_n           <= 1'b0;
        query_valid     <= 1'b0;
        query           <= '0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: short query, exact header only, header plus one byte
        send_query_byte(8'h00, 1'b1);
        send_query(12, 8'h00);
        for (int i = 0; i < 12; i++)
            send_query_byte(8'hFF, 1'b0);
        send_query_byte(8'hA5, 1'b1);
        wait_replies_drained();

        write_answer_ipv4(IPV4_ONES);
        send_random_queries(PHASE_BYTES);
        wait_replies_drained();

        write_answer_ipv4($urandom);
        send_idle_pct = 77;
        send_random_queries(PHASE_BYTES);
        wait_replies_drained();

        write_answer_ipv4(IPV4_ZERO);
        send_idle_pct  = 0;
        recv_stall_pct = 77;
        send_random_queries(PHASE_BYTES);
        wait_replies_drained();

        write_answer_ipv4($urandom);
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        send_random_queries(PHASE_BYTES);
        wait_replies_drained();

        // reply side held off while queries keep coming, backing up the queue
        write_answer_ipv4($urandom);
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        holdoff_request = HOLDOFF_LEN;
        send_random_queries(HOLD_BYTES);
        wait_replies_drained();

        if (reply_model.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
